>>> rtl/pec_pkg.sv
// shared types, constants and type classification for the partition entry checker
`timescale 1ns / 1ps
`default_nettype none
package pec_pkg;

	localparam int LBA_W = 32;
	localparam int HC_W  = 9;
	localparam int SPT_W = 6;
	localparam int CFG_W = 9;

	// configuration register indexes
	localparam logic CFG_HEAD_COUNT = 1'b0;
	localparam logic CFG_SECTORS    = 1'b1;

	localparam logic [HC_W-1:0]  HEAD_COUNT_RST = 9'd255;
	localparam logic [SPT_W-1:0] SECTORS_RST    = 6'd63;

	// partition type codes
	localparam logic [7:0] PT_UNUSED    = 8'h00;
	localparam logic [7:0] PT_EXT_CHS   = 8'h05;
	localparam logic [7:0] PT_EXT_LBA   = 8'h0F;
	localparam logic [7:0] PT_EXT_HID   = 8'h1E;
	localparam logic [7:0] PT_FAT16     = 8'h06;
	localparam logic [7:0] PT_FAT32     = 8'h0B;
	localparam logic [7:0] PT_FAT32_LBA = 8'h0C;
	localparam logic [7:0] PT_FAT16_LBA = 8'h0E;
	localparam logic [7:0] PT_FAT32_HID = 8'h1B;
	localparam logic [7:0] PT_FAT32_HLB = 8'h1C;
	localparam logic [7:0] PT_LINUX     = 8'h83;

	typedef enum logic [1:0] {
		KIND_OTHER    = 2'd0,
		KIND_EXTENDED = 2'd1,
		KIND_FAT      = 2'd2,
		KIND_EXT2     = 2'd3
	} kind_t;

	// entry data that travels beside the chs lanes
	typedef struct packed {
		logic [7:0]       part_type;
		logic [LBA_W-1:0] start_lba;
		logic [LBA_W-1:0] end_lba;
	} lba_t;

	function automatic kind_t classify(input logic [7:0] t);
		kind_t k;
		k = KIND_OTHER;
		if (t inside {PT_EXT_CHS, PT_EXT_LBA, PT_EXT_HID})
			k = KIND_EXTENDED;
		else if (t inside {PT_FAT16, PT_FAT32, PT_FAT32_LBA, PT_FAT16_LBA,
				PT_FAT32_HID, PT_FAT32_HLB})
			k = KIND_FAT;
		else if (t == PT_LINUX)
			k = KIND_EXT2;
		return k;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pec_chs_lane.sv
// one chs to lba lane: two multiply stages
`timescale 1ns / 1ps
`default_nettype none
module pec_chs_lane
	import pec_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en_s1,
	input  wire logic             en_s2,
	input  wire logic [7:0]       head,
	input  wire logic [7:0]       sector_byte,
	input  wire logic [7:0]       cyl_low,
	input  wire logic [HC_W-1:0]  head_count,
	input  wire logic [SPT_W-1:0] sectors_per_track,
	output logic      [LBA_W-1:0] lba_s2
);

	logic [9:0]  cyl;
	logic [18:0] cyl_heads;
	logic [19:0] track_s1;
	logic [5:0]  sec_s1;
	logic [25:0] scaled;

	// cylinder bits 8-9 live in the top of the sector byte
	assign cyl       = {sector_byte[7:6], cyl_low};
	assign cyl_heads = 19'(cyl) * 19'(head_count);
	assign scaled    = 26'(track_s1) * 26'(sectors_per_track);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			track_s1 <= 20'(cyl_heads) + 20'(head);
			sec_s1   <= sector_byte[5:0];
		end
	end

	// sector zero yields the scaled track minus one, wrapping to all ones when that is zero
	always_ff @(posedge clk) begin
		if (en_s2) begin
			lba_s2 <= 32'(scaled) + 32'(sec_s1) - 32'd1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pec_merge.sv
// merge stage: compares lane results with the table lba, classifies, holds output
`timescale 1ns / 1ps
`default_nettype none
module pec_merge
	import pec_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s2,
	input  wire lba_t             ent_s2,
	input  wire logic [LBA_W-1:0] chs_start_s2,
	input  wire logic [LBA_W-1:0] chs_end_s2,
	output logic                  ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  present,
	output logic      [LBA_W-1:0] start_lba,
	output logic      [LBA_W-1:0] end_lba,
	output logic      [LBA_W-1:0] chs_start_lba,
	output logic      [LBA_W-1:0] chs_end_lba,
	output logic                  start_mismatch,
	output logic                  end_mismatch,
	output kind_t                 kind
);

	logic out_valid_q;
	logic used;

	assign ready     = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;
	assign used      = (ent_s2.part_type != PT_UNUSED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready) begin
			out_valid_q <= valid_s2;
		end
	end

	// an unused entry reports all zeros
	always_ff @(posedge clk) begin
		if (ready) begin
			present        <= used;
			start_lba      <= used ? ent_s2.start_lba : '0;
			end_lba        <= used ? ent_s2.end_lba : '0;
			chs_start_lba  <= used ? chs_start_s2 : '0;
			chs_end_lba    <= used ? chs_end_s2 : '0;
			start_mismatch <= used && (ent_s2.start_lba != chs_start_s2);
			end_mismatch   <= used && (ent_s2.end_lba != chs_end_s2);
			kind           <= classify(ent_s2.part_type);
		end
	end

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && valid_s2) |=> out_valid_q)
		else $error("loaded entry not shown at output");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !present) |-> (start_lba == '0 && end_lba == '0 &&
		chs_start_lba == '0 && chs_end_lba == '0 && !start_mismatch &&
		!end_mismatch && kind == KIND_OTHER))
		else $error("unused entry reports nonzero fields");

	a_mismatch_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && present) |->
		(start_mismatch == (start_lba != chs_start_lba) &&
		end_mismatch == (end_lba != chs_end_lba)))
		else $error("mismatch flags disagree with reported lba");

endmodule
`default_nettype wire

>>> rtl/partition_entry_checker_unit.sv
// top level of the partition entry checker
// Checks one partition table entry per transfer against the configured disk geometry.
// Input: s_axis stream, one entry per transfer, fields packed in s_axis_tdata.
// Output: m_axis stream, one result per entry in the same order; kind rides in tuser.
// Configuration: cfg_wr_en/cfg_index/cfg_data write head_count (index 0) and
// sectors_per_track (index 1); write only while no entry is in flight.
// Two chs lanes (start and end tuple) run beside the lba adders; a merge stage
// compares and classifies.
// Pipeline: three register stages (lane multiply, lane scale, merge register).
// Throughput: one entry per cycle while m_axis_tready does not hold the output.
// Stalls: each stage moves when the stage after it is empty or moving, so bubbles
// fill while m_axis_tready is low and input is taken until all three stages hold
// an entry; s_axis_tready then follows m_axis_tready.
// Reset: the pipeline empties and the geometry returns to 255 heads and
// 63 sectors per track.
`timescale 1ns / 1ps
`default_nettype none
module partition_entry_checker_unit
	import pec_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// start_head, start_sector_byte, start_cyl_low, part_type, end_head,
	// end_sector_byte, end_cyl_low, start_offset, part_length, table_base
	input  wire logic [151:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// present, start_lba, end_lba, chs_start_lba, chs_end_lba, start_mismatch,
	// end_mismatch, zero pad
	output logic      [135:0] m_axis_tdata,
	// kind
	output logic      [1:0]   m_axis_tuser,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [HC_W-1:0]  head_count_q;
	logic [SPT_W-1:0] sectors_q;

	logic valid_s1, valid_s2;
	logic adv_s1, adv_s2;
	logic merge_ready;

	logic [7:0]       part_type_s1;
	logic [LBA_W-1:0] start_lba_s1;
	logic [LBA_W-1:0] length_s1;
	lba_t             ent_s2;
	logic [LBA_W-1:0] chs_start_s2, chs_end_s2;

	logic             present, start_mismatch, end_mismatch;
	logic [LBA_W-1:0] start_lba, end_lba, chs_start_lba, chs_end_lba;
	kind_t            kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_count_q <= HEAD_COUNT_RST;
			sectors_q    <= SECTORS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_HEAD_COUNT: head_count_q <= cfg_data[HC_W-1:0];
				CFG_SECTORS:    sectors_q    <= cfg_data[SPT_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s2        = ~valid_s2 | merge_ready;
	assign adv_s1        = ~valid_s1 | adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_axis_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			part_type_s1 <= s_axis_tdata[31:24];
			start_lba_s1 <= s_axis_tdata[87:56] + s_axis_tdata[151:120];
			length_s1    <= s_axis_tdata[119:88];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			ent_s2.part_type <= part_type_s1;
			ent_s2.start_lba <= start_lba_s1;
			ent_s2.end_lba   <= start_lba_s1 + length_s1 - 32'd1;
		end
	end

	pec_chs_lane u_lane_start (
		.clk               (clk),
		.en_s1             (adv_s1),
		.en_s2             (adv_s2),
		.head              (s_axis_tdata[7:0]),
		.sector_byte       (s_axis_tdata[15:8]),
		.cyl_low           (s_axis_tdata[23:16]),
		.head_count        (head_count_q),
		.sectors_per_track (sectors_q),
		.lba_s2            (chs_start_s2)
	);

	pec_chs_lane u_lane_end (
		.clk               (clk),
		.en_s1             (adv_s1),
		.en_s2             (adv_s2),
		.head              (s_axis_tdata[39:32]),
		.sector_byte       (s_axis_tdata[47:40]),
		.cyl_low           (s_axis_tdata[55:48]),
		.head_count        (head_count_q),
		.sectors_per_track (sectors_q),
		.lba_s2            (chs_end_s2)
	);

	pec_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s2       (valid_s2),
		.ent_s2         (ent_s2),
		.chs_start_s2   (chs_start_s2),
		.chs_end_s2     (chs_end_s2),
		.ready          (merge_ready),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.present        (present),
		.start_lba      (start_lba),
		.end_lba        (end_lba),
		.chs_start_lba  (chs_start_lba),
		.chs_end_lba    (chs_end_lba),
		.start_mismatch (start_mismatch),
		.end_mismatch   (end_mismatch),
		.kind           (kind)
	);

	assign m_axis_tdata = {5'd0, end_mismatch, start_mismatch, chs_end_lba, chs_start_lba,
		end_lba, start_lba, present};
	assign m_axis_tuser = kind;

endmodule
`default_nettype wire

>>> tb/pec_result_monitor.sv
// result monitor for the partition entry checker: predicts each result and compares
`timescale 1ns / 1ps
module pec_result_monitor
	import pec_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	input  wire logic             s_axis_tready,
	// start_head, start_sector_byte, start_cyl_low, part_type, end_head,
	// end_sector_byte, end_cyl_low, start_offset, part_length, table_base
	input  wire logic [151:0]     s_axis_tdata,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// present, start_lba, end_lba, chs_start_lba, chs_end_lba, start_mismatch,
	// end_mismatch, zero pad
	input  wire logic [135:0]     m_axis_tdata,
	// kind
	input  wire logic [1:0]       m_axis_tuser,
	input  wire logic             cfg_wr_en,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [31:0] table_base;
		logic [31:0] part_length;
		logic [31:0] start_offset;
		logic [7:0]  end_cyl_low;
		logic [7:0]  end_sector_byte;
		logic [7:0]  end_head;
		logic [7:0]  part_type;
		logic [7:0]  start_cyl_low;
		logic [7:0]  start_sector_byte;
		logic [7:0]  start_head;
	} entry_t;

	typedef struct packed {
		logic [4:0]  pad;
		logic        end_mismatch;
		logic        start_mismatch;
		logic [31:0] chs_end_lba;
		logic [31:0] chs_start_lba;
		logic [31:0] end_lba;
		logic [31:0] start_lba;
		logic        present;
	} check_t;

	typedef struct packed {
		kind_t  kind;
		check_t data;
	} outcome_t;

	logic [HC_W-1:0]  geo_heads;
	logic [SPT_W-1:0] geo_spt;
	outcome_t         expected_checks[$];
	outcome_t         want;
	check_t           got;

	initial fail_count = 0;

	// all arithmetic wraps at 32 bits, including a zero sector field
	function automatic logic [31:0] chs_lba(logic [7:0] head, logic [7:0] sec_byte,
			logic [7:0] cyl_low, logic [HC_W-1:0] heads, logic [SPT_W-1:0] spt);
		logic [31:0] cyl;
		logic [31:0] v;
		cyl = {22'd0, sec_byte[7:6], cyl_low};
		v = cyl * {23'd0, heads} + {24'd0, head};
		v = v * {26'd0, spt};
		return v + {26'd0, sec_byte[5:0]} - 32'd1;
	endfunction

	function automatic kind_t type_class(logic [7:0] t);
		case (t)
			PT_EXT_CHS, PT_EXT_LBA, PT_EXT_HID: return KIND_EXTENDED;
			PT_FAT16, PT_FAT32, PT_FAT32_LBA, PT_FAT16_LBA, PT_FAT32_HID,
			PT_FAT32_HLB: return KIND_FAT;
			PT_LINUX: return KIND_EXT2;
			default: return KIND_OTHER;
		endcase
	endfunction

	function automatic outcome_t predict_entry_check(entry_t e, logic [HC_W-1:0] heads,
			logic [SPT_W-1:0] spt);
		outcome_t o;
		o = '0;
		// an unused entry reports nothing at all
		if (e.part_type != PT_UNUSED) begin
			o.data.present = 1'b1;
			o.data.start_lba = e.start_offset + e.table_base;
			o.data.end_lba = o.data.start_lba + e.part_length - 32'd1;
			o.data.chs_start_lba = chs_lba(e.start_head, e.start_sector_byte,
				e.start_cyl_low, heads, spt);
			o.data.chs_end_lba = chs_lba(e.end_head, e.end_sector_byte,
				e.end_cyl_low, heads, spt);
			o.data.start_mismatch = o.data.start_lba != o.data.chs_start_lba;
			o.data.end_mismatch = o.data.end_lba != o.data.chs_end_lba;
			o.kind = type_class(e.part_type);
		end
		return o;
	endfunction

	task automatic note(string what, logic [31:0] exp_v, logic [31:0] act_v);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_heads <= HEAD_COUNT_RST;
			geo_spt <= SECTORS_RST;
			expected_checks.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_HEAD_COUNT)
					geo_heads <= cfg_data;
				else
					geo_spt <= cfg_data[SPT_W-1:0];
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_checks.push_back(predict_entry_check(entry_t'(s_axis_tdata),
					geo_heads, geo_spt));
			if (m_axis_tvalid && m_axis_tready) begin
				got = check_t'(m_axis_tdata);
				if (expected_checks.size() == 0) begin
					note("result transfer with nothing pending", 32'd0, {31'd0, got.present});
				end else begin
					want = expected_checks.pop_front();
					if (got.present !== want.data.present)
						note("present", 32'(want.data.present), 32'(got.present));
					if (got.start_lba !== want.data.start_lba)
						note("start_lba", want.data.start_lba, got.start_lba);
					if (got.end_lba !== want.data.end_lba)
						note("end_lba", want.data.end_lba, got.end_lba);
					if (got.chs_start_lba !== want.data.chs_start_lba)
						note("chs_start_lba", want.data.chs_start_lba, got.chs_start_lba);
					if (got.chs_end_lba !== want.data.chs_end_lba)
						note("chs_end_lba", want.data.chs_end_lba, got.chs_end_lba);
					if (got.start_mismatch !== want.data.start_mismatch)
						note("start_mismatch", 32'(want.data.start_mismatch),
							32'(got.start_mismatch));
					if (got.end_mismatch !== want.data.end_mismatch)
						note("end_mismatch", 32'(want.data.end_mismatch),
							32'(got.end_mismatch));
					if (got.pad !== 5'd0)
						note("tdata pad", 32'd0, 32'(got.pad));
					if (m_axis_tuser !== want.kind)
						note("kind", 32'(want.kind), 32'(m_axis_tuser));
				end
			end
			pending <= expected_checks.size();
		end
	end

endmodule

>>> tb/tb_partition_entry_checker_unit.sv
// testbench top for the partition entry checker: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module tb_partition_entry_checker_unit;
	import pec_pkg::*;

	typedef struct packed {
		logic [31:0] table_base;
		logic [31:0] part_length;
		logic [31:0] start_offset;
		logic [7:0]  end_cyl_low;
		logic [7:0]  end_sector_byte;
		logic [7:0]  end_head;
		logic [7:0]  part_type;
		logic [7:0]  start_cyl_low;
		logic [7:0]  start_sector_byte;
		logic [7:0]  start_head;
	} entry_t;

	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 210;
	// types with no class of their own
	localparam logic [7:0] PT_NTFS = 8'h07;
	localparam logic [7:0] PT_FAT12 = 8'h01;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [151:0]         s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [135:0]         m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_wr_en = 1'b0;
	logic                 cfg_index = CFG_HEAD_COUNT;
	logic [CFG_W-1:0]     cfg_data = '0;
	int                   fail_count;
	int                   pending;

	bit                   tx_idle = 1'b1;
	bit                   rx_idle = 1'b1;
	bit                   rx_hold = 1'b0;
	logic [HC_W-1:0]      geo_heads = HEAD_COUNT_RST;
	logic [SPT_W-1:0]     geo_spt = SECTORS_RST;
	logic [7:0]           known_types [10] = '{PT_EXT_CHS, PT_EXT_LBA, PT_EXT_HID,
		PT_FAT16, PT_FAT32, PT_FAT32_LBA, PT_FAT16_LBA, PT_FAT32_HID, PT_FAT32_HLB,
		PT_LINUX};
	logic [HC_W-1:0]      phase_heads [PHASES] = '{9'd255, 9'd1, 9'd256, 9'd0,
		9'd511, 9'd16, 9'd128, 9'd2};
	logic [SPT_W-1:0]     phase_spt [PHASES] = '{6'd63, 6'd1, 6'd63, 6'd0,
		6'd63, 6'd63, 6'd32, 6'd17};

	always #1 clk = ~clk;

	partition_entry_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pec_result_monitor monitor (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		#400000;
		$display("tb_partition_entry_checker_unit NOT OK");
		$finish;
	end

	// result side: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic entry_t random_entry();
		logic [159:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return r[151:0];
	endfunction

	function automatic entry_t entry_of(logic [7:0] ptype, logic [7:0] sh, logic [7:0] ssb,
			logic [7:0] scl, logic [7:0] eh, logic [7:0] esb, logic [7:0] ecl,
			logic [31:0] offset, logic [31:0] length, logic [31:0] base);
		entry_t e;
		e.part_type = ptype;
		e.start_head = sh;
		e.start_sector_byte = ssb;
		e.start_cyl_low = scl;
		e.end_head = eh;
		e.end_sector_byte = esb;
		e.end_cyl_low = ecl;
		e.start_offset = offset;
		e.part_length = length;
		e.table_base = base;
		return e;
	endfunction

	function automatic logic [31:0] geometry_lba(logic [9:0] cyl, logic [7:0] head,
			logic [5:0] sec);
		return ({22'd0, cyl} * {23'd0, geo_heads} + {24'd0, head}) * {26'd0, geo_spt}
			+ {26'd0, sec} - 32'd1;
	endfunction

	function automatic logic [7:0] pick_head();
		if (geo_heads >= 9'd1 && geo_heads <= 9'd256)
			return 8'($urandom_range(0, geo_heads - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [5:0] pick_sector();
		if (geo_spt != 6'd0)
			return 6'($urandom_range(1, geo_spt));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] pick_type();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return PT_UNUSED;
		if (r < 7)
			return known_types[$urandom_range(0, 9)];
		return 8'($urandom_range(0, 255));
	endfunction

	// entry whose lba fields agree with its chs tuples, now and then nudged off
	function automatic entry_t plausible_entry(logic [7:0] ptype);
		entry_t e;
		logic [9:0] sc;
		logic [9:0] ec;
		logic [7:0] sh;
		logic [7:0] eh;
		logic [5:0] ss;
		logic [5:0] es;
		logic [31:0] slba;
		logic [31:0] elba;
		e = random_entry();
		sc = 10'($urandom_range(0, 1023));
		ec = 10'($urandom_range(sc, 1023));
		sh = pick_head();
		eh = pick_head();
		ss = pick_sector();
		es = pick_sector();
		e.part_type = ptype;
		e.start_head = sh;
		e.start_sector_byte = {sc[9:8], ss};
		e.start_cyl_low = sc[7:0];
		e.end_head = eh;
		e.end_sector_byte = {ec[9:8], es};
		e.end_cyl_low = ec[7:0];
		slba = geometry_lba(sc, sh, ss);
		elba = geometry_lba(ec, eh, es);
		if ($urandom_range(0, 3) == 0)
			e.table_base = $urandom_range(0, 63);
		e.start_offset = slba - e.table_base;
		e.part_length = elba - slba + 32'd1;
		case ($urandom_range(0, 7))
			0: e.start_offset = e.start_offset ^ (32'd1 << $urandom_range(0, 31));
			1: e.part_length = e.part_length + 32'($urandom_range(1, 3));
			default: ;
		endcase
		return e;
	endfunction

	task automatic send_entry(entry_t e);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= random_entry();
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= e;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and let every pending result come out
	task automatic halt_and_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_geometry(logic [HC_W-1:0] heads, logic [SPT_W-1:0] spt);
		halt_and_drain();
		write_reg(CFG_HEAD_COUNT, heads);
		// upper data bits are junk for the narrower register
		write_reg(CFG_SECTORS, {3'($urandom_range(0, 7)), spt});
		geo_heads = heads;
		geo_spt = spt;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused entries, with empty and with full fields, and a full entry of type ff
		send_entry(entry_of(PT_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			32'd0, 32'd0, 32'd0));
		send_entry(entry_of(PT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_entry(entry_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// sector field of zero at cylinder zero
		send_entry(entry_of(PT_LINUX, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			32'd0, 32'd0, 32'd0));
		// lba sums wrap past the top
		send_entry(entry_of(PT_FAT32, 8'h01, 8'h01, 8'h00, 8'h02, 8'h3F, 8'h10,
			32'hFFFF_FFF0, 32'd0, 32'h0000_0020));
		// highest cylinder through the sector byte's top bits
		send_entry(entry_of(PT_EXT_LBA, 8'h00, 8'hC1, 8'hFF, 8'hFE, 8'hFF, 8'hFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'd446));
		foreach (known_types[i])
			send_entry(plausible_entry(known_types[i]));
		send_entry(plausible_entry(PT_NTFS));
		send_entry(plausible_entry(PT_FAT12));
		send_entry(plausible_entry(8'h80));

		for (int p = 0; p < PHASES; p++) begin
			tx_idle = (p != PHASES - 1) && (p % 3 != 1);
			rx_idle = (p != PHASES - 1) && (p % 3 != 2);
			set_geometry(phase_heads[p], phase_spt[p]);
			if (p == 3) begin
				tx_idle = 1'b0;
				rx_hold = 1'b1;
			end
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 2) == 0)
					send_entry(random_entry());
				else
					send_entry(plausible_entry(pick_type()));
			end
		end
		halt_and_drain();

		if (fail_count == 0 && pending == 0)
			$display("tb_partition_entry_checker_unit OK");
		else
			$display("tb_partition_entry_checker_unit NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/pec_pkg.sv
rtl/pec_chs_lane.sv
rtl/pec_merge.sv
rtl/partition_entry_checker_unit.sv
tb/pec_result_monitor.sv
tb/tb_partition_entry_checker_unit.sv
